@@ rtl/bitmap_block_allocator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define BBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BBA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Payload types, status codes and control structs shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int WORD_W  = 8;
    localparam logic [COUNT_W-1:0] INDEX_SPAN    = 13'd4096;
    localparam logic [COUNT_W-1:0] COUNT_RESET   = 13'd4096;
    localparam int                 MAX_WORDS     = 512;
    localparam logic [WORD_W-1:0]  WORD_FULL     = 8'hFF;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NONE_FREE    = 2'd1,
        STATUS_RANGE        = 2'd2,
        STATUS_ALREADY_FREE = 2'd3
    } status_t;

    typedef struct packed {
        logic               opcode;
        logic [INDEX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [INDEX_W-1:0] allocated_index;
    } resp_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_wr;
        logic req_load;
        logic look;
        logic hint_inc;
        logic eval;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic early;
        logic word_full;
    } sts_t;

    // lowest clear bit of a byte, LSB first
    function automatic logic [2:0] first_zero(input logic [WORD_W-1:0] v);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/bitmap_block_allocator_top.sv @@
// Bitmap block allocator, first fit.
// Input channel (in_valid/in_stall/in_data) takes allocate or free requests;
// output channel (out_valid/out_stall/out_data) returns one result per request
// with status and the granted block index. cfg_we/cfg_wdata write block_count;
// the user must write it only while the block is idle; the block does not enforce this.
// After reset the bitmap RAM is swept to zero, one word a cycle, over all
// min((NUM_BLOCKS+7)/8, 512) words (512 at the defaults); in_stall is high
// during the sweep. block_count resets to 4096.
// An accepted request reads its bitmap word in ST_LOOK, checks it in ST_EVAL
// and has its result loaded into the output register from ST_DONE; a range or
// no-free answer decided from the limit alone goes from ST_LOOK straight to
// ST_DONE. An allocate repeats ST_LOOK and ST_EVAL for every full bitmap word
// stepped over past the search hint (one RAM read and one check per word). The
// next request is accepted the cycle after the result is loaded, not before.
// While the receiver stalls, the result waits in the output register and one
// more request may be taken and worked; its result then waits until the
// output register is taken.
// ----------------------------------------------------------------------------
// Bitmap block allocator top level
// Joins the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_block_allocator_top #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  bba_pkg::req_t               in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output bba_pkg::resp_t              out_data,
    input  logic                        cfg_we,
    input  logic [bba_pkg::COUNT_W-1:0] cfg_wdata
);
    import bba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_datapath #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

@@ rtl/bba_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator controller
// Sequences clearing, request intake, bitmap lookup and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);
    import bba_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOOK  = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = sts.early ? ST_DONE : ST_EVAL;
            end
            ST_EVAL:
            begin
                // full word: step the hint and look again
                if (sts.word_full)
                begin
                    cmd.hint_inc = 1'b1;
                    state_next   = ST_LOOK;
                end
                else
                begin
                    cmd.eval   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/bba_datapath.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator datapath
// Bitmap RAM, search hint, limit compare, bit search and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_datapath #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bba_pkg::req_t                   in_data,
    output bba_pkg::resp_t                  out_data,
    input  logic                            cfg_we,
    input  logic [bba_pkg::COUNT_W-1:0]     cfg_wdata,
    input  bba_pkg::cmd_t                   cmd,
    output bba_pkg::sts_t                   sts
);
    import bba_pkg::*;

    localparam int MAP_BYTES = (NUM_BLOCKS + 7) / 8;
    // words past the 12-bit index span are never reached
    localparam int MEM_DEPTH = (MAP_BYTES < MAX_WORDS) ? MAP_BYTES : MAX_WORDS;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int HW        = $clog2(MEM_DEPTH + 1);
    localparam int CAP_INT   = (NUM_BLOCKS < 4096) ? NUM_BLOCKS : 4096;
    localparam logic [COUNT_W-1:0] CAP       = COUNT_W'(CAP_INT);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(MEM_DEPTH - 1);

    logic [COUNT_W-1:0] block_count_reg;
    logic [HW-1:0]      hint_reg, hint_next;
    logic [AW-1:0]      clr_addr_reg;
    logic               op_reg;
    logic [INDEX_W-1:0] idx_reg;
    resp_t              pend_reg, pend_next;
    resp_t              out_data_reg;

    logic [COUNT_W-1:0] lim;
    logic [COUNT_W-1:0] base;
    logic [COUNT_W-1:0] cand;
    logic [8:0]         free_word;
    logic [WORD_W-1:0]  rd_data;
    logic [2:0]         zbit;
    logic [WORD_W-1:0]  alloc_mask;
    logic [WORD_W-1:0]  free_mask;
    logic               early;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;

    assign lim        = (block_count_reg > CAP) ? CAP : block_count_reg;
    assign base       = COUNT_W'({hint_reg, 3'b000});
    assign free_word  = idx_reg[INDEX_W-1:3];
    assign zbit       = first_zero(rd_data);
    assign cand       = base + COUNT_W'(zbit);
    assign alloc_mask = WORD_W'(1) << zbit;
    assign free_mask  = WORD_W'(1) << idx_reg[2:0];
    assign early      = (op_reg == OP_ALLOC) ? (base >= lim)
                                             : ({1'b0, idx_reg} >= lim);

    assign ram_raddr  = (op_reg == OP_FREE) ? AW'(free_word) : AW'(hint_reg);

    always_comb
    begin
        hint_next = hint_reg;
        pend_next = pend_reg;
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        if (cmd.clear_wr)
        begin
            ram_we = 1'b1;
        end
        if (cmd.hint_inc)
        begin
            hint_next = hint_reg + HW'(1);
        end
        if (cmd.look && early)
        begin
            pend_next.status          = (op_reg == OP_ALLOC) ? STATUS_NONE_FREE
                                                             : STATUS_RANGE;
            pend_next.allocated_index = '0;
        end
        if (cmd.eval)
        begin
            pend_next.allocated_index = '0;
            if (op_reg == OP_ALLOC)
            begin
                if (cand < lim)
                begin
                    ram_we                    = 1'b1;
                    ram_waddr                 = AW'(hint_reg);
                    ram_wdata                 = rd_data | alloc_mask;
                    pend_next.status          = STATUS_OK;
                    pend_next.allocated_index = cand[INDEX_W-1:0];
                end
                else
                begin
                    pend_next.status = STATUS_NONE_FREE;
                end
            end
            else
            begin
                if ((rd_data & free_mask) != '0)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = AW'(free_word);
                    ram_wdata        = rd_data & ~free_mask;
                    pend_next.status = STATUS_OK;
                    // keep every word below the hint full
                    if (COUNT_W'(free_word) < COUNT_W'(hint_reg))
                    begin
                        hint_next = HW'(free_word);
                    end
                end
                else
                begin
                    pend_next.status = STATUS_ALREADY_FREE;
                end
            end
        end
    end

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH),
        .ADDR_W(AW)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= COUNT_RESET;
            hint_reg        <= '0;
            clr_addr_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_count_reg <= cfg_wdata;
            end
            hint_reg <= hint_next;
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            op_reg  <= in_data.opcode;
            idx_reg <= in_data.block_index;
        end
        pend_reg <= pend_next;
        if (cmd.out_load)
        begin
            out_data_reg <= pend_reg;
        end
    end

    assign sts.clear_last = (clr_addr_reg == LAST_ADDR);
    assign sts.early      = early;
    assign sts.word_full  = (op_reg == OP_ALLOC) && (rd_data == WORD_FULL);
    assign out_data       = out_data_reg;

endmodule

@@ rtl/bba_checker.sv @@
// ----------------------------------------------------------------------------
// Bitmap block allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_block_allocator_top_defines.svh"

module bba_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input logic           out_valid,
    input logic           out_stall,
    input bba_pkg::resp_t out_data
);
    import bba_pkg::*;

    `BBA_ASSERT_RST(a_rst_no_out, !rst_n |-> !out_valid, "result valid during reset")
    `BBA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
    `BBA_ASSERT(a_err_zero, out_valid && (out_data.status != STATUS_OK) |-> (out_data.allocated_index == '0), "error result with nonzero index")
    `BBA_ASSERT(a_min_latency, in_valid && !in_stall |=> !$rose(out_valid), "result one cycle after request")

endmodule

bind bitmap_block_allocator_top bba_checker u_checker (.*);

@@ tb/bba_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap allocator result checker
// Watches the request, result and block_count ports. It keeps its own bitmap
// and block count, works out the answer to every accepted request, and checks
// each accepted result, field by field, against the oldest answer still owed.
// ----------------------------------------------------------------------------

module bba_result_checker #(
    parameter int NUM_BLOCKS = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  bba_pkg::req_t               in_data,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  bba_pkg::resp_t              out_data,
    input  logic                        cfg_we,
    input  logic [bba_pkg::COUNT_W-1:0] cfg_wdata,
    output int                          fail_count,
    output int                          pending
);

    import bba_pkg::*;

    localparam int SPAN = int'(INDEX_SPAN);

    logic [SPAN-1:0]    used_bits;
    logic [COUNT_W-1:0] blk_count;
    resp_t              owed_results[$];
    resp_t              oldest;
    int                 mismatches = 0;

    assign fail_count = mismatches;

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Usable blocks: block_count clipped to the capacity and the index span.
    function automatic int block_limit();
        int lim;
        lim = int'(blk_count);
        if (lim > NUM_BLOCKS)
        begin
            lim = NUM_BLOCKS;
        end
        if (lim > SPAN)
        begin
            lim = SPAN;
        end
        return lim;
    endfunction

    function automatic resp_t serve_request(input req_t rq);
        resp_t r;
        int    lim;
        int    i;
        logic  found;
        lim               = block_limit();
        r.status          = STATUS_OK;
        r.allocated_index = '0;
        found             = 1'b0;
        if (rq.opcode == OP_ALLOC)
        begin
            for (i = 0; i < lim && !found; i++)
            begin
                if (!used_bits[i])
                begin
                    used_bits[i]      = 1'b1;
                    r.allocated_index = i[INDEX_W-1:0];
                    found             = 1'b1;
                end
            end
            if (!found)
            begin
                r.status = STATUS_NONE_FREE;
            end
        end
        else if (int'(rq.block_index) >= lim)
        begin
            r.status = STATUS_RANGE;
        end
        else if (!used_bits[rq.block_index])
        begin
            r.status = STATUS_ALREADY_FREE;
        end
        else
        begin
            used_bits[rq.block_index] = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_bits = '0;
            blk_count = COUNT_RESET;
            owed_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                blk_count = cfg_wdata;
            end
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    flag_mismatch("result with no request owed", int'(out_data), 0);
                end
                else
                begin
                    oldest = owed_results.pop_front();
                    if (out_data.status != oldest.status)
                    begin
                        flag_mismatch("status", int'(out_data.status), int'(oldest.status));
                    end
                    if (out_data.allocated_index != oldest.allocated_index)
                    begin
                        flag_mismatch("allocated_index", int'(out_data.allocated_index),
                                      int'(oldest.allocated_index));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                owed_results.push_back(serve_request(in_data));
            end
            pending = owed_results.size();
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap allocator testbench top
// Drives allocate and free requests through the block under several block
// counts, with random gaps and stalls on both sides, a long output hold-off
// and a stretch with no idling. Results are checked by the result checker.
// ----------------------------------------------------------------------------

module tb;

    import bba_pkg::*;

    localparam int STUCK_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 9;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    req_t               in_data;
    logic               out_valid;
    logic               out_stall;
    resp_t              out_data;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 pending;

    logic               idling;
    logic               hold_req;
    int                 lim_now;
    int                 fill_guess;
    int                 stuck;

    bitmap_block_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bba_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // receiver: random stalls, or one long hold-off when asked
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                out_stall = idling && ($urandom_range(99) < 20);
            end
        end
    end

    initial
    begin
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                stuck = 0;
            end
            else
            begin
                stuck++;
            end
        end
        $display("bitmap_block_allocator_top: mismatch");
        $finish;
    end

    task automatic offer(input logic op, input logic [INDEX_W-1:0] idx);
        req_t rq;
        rq.opcode      = op;
        rq.block_index = idx;
        @(negedge clk);
        while (idling && $urandom_range(99) < 20)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = rq;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // stop offering and let every owed result come back
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_count(input int value);
        settle();
        cfg_we    = 1'b1;
        cfg_wdata = value[COUNT_W-1:0];
        @(negedge clk);
        cfg_we  = 1'b0;
        lim_now = (value > int'(INDEX_SPAN)) ? int'(INDEX_SPAN) : value;
    endtask

    function automatic int clip_index(input int v);
        return (v > int'(INDEX_SPAN) - 1) ? int'(INDEX_SPAN) - 1 : v;
    endfunction

    // allocates at alloc_pct; else mostly frees of blocks likely to be held, plus out-of-range and noise
    task automatic random_request(input int alloc_pct);
        int r;
        r = $urandom_range(99);
        if (r < alloc_pct)
        begin
            offer(OP_ALLOC, INDEX_W'($urandom));
            if (fill_guess < lim_now)
            begin
                fill_guess++;
            end
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 65)
            begin
                offer(OP_FREE, INDEX_W'($urandom_range(0, clip_index(fill_guess + 4))));
            end
            else if (r < 88)
            begin
                offer(OP_FREE, INDEX_W'($urandom_range(0, clip_index(lim_now + 3))));
            end
            else
            begin
                offer(OP_FREE, INDEX_W'($urandom));
            end
            if (fill_guess > 0)
            begin
                fill_guess--;
            end
        end
    endtask

    initial
    begin
        int phase_count [NUM_PHASES];
        int phase;
        int n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        idling     = 1'b1;
        hold_req   = 1'b0;
        lim_now    = int'(COUNT_RESET);
        fill_guess = 0;
        phase_count = '{4096, 0, 1, 37, 8191, 200, 12, 4096, 0};
        phase_count[8] = $urandom_range(2, 600);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset count, double free, top index
        offer(OP_ALLOC, '0);
        offer(OP_ALLOC, '1);
        offer(OP_ALLOC, 12'h555);
        offer(OP_FREE, 12'd1);
        offer(OP_FREE, 12'd1);
        offer(OP_ALLOC, 12'hAAA);
        offer(OP_FREE, 12'd4095);
        offer(OP_FREE, 12'd0);
        offer(OP_FREE, 12'd0);
        // zero blocks: nothing free, everything out of range
        write_count(0);
        offer(OP_ALLOC, '0);
        offer(OP_FREE, 12'd0);
        offer(OP_FREE, 12'd4095);
        // lowered count: blocks 1 and 2 stay held above nothing
        write_count(3);
        offer(OP_ALLOC, '0);
        offer(OP_ALLOC, '0);
        offer(OP_FREE, 12'd3);
        offer(OP_FREE, 12'd2);
        offer(OP_ALLOC, '0);
        offer(OP_ALLOC, '0);
        // count above capacity acts as the capacity
        write_count(8191);
        offer(OP_ALLOC, '0);
        offer(OP_FREE, 12'd4095);
        offer(OP_FREE, 12'd2);
        offer(OP_FREE, 12'd1);
        fill_guess = 4;

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_count(phase_count[phase]);
            idling = (phase != 3);
            if (phase == 4)
            begin
                hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                random_request((phase % 2 == 0) ? 55 : 70);
            end
        end
        idling = 1'b1;
        settle();

        if (fail_count == 0)
        begin
            $display("bitmap_block_allocator_top: match");
        end
        else
        begin
            $display("bitmap_block_allocator_top: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_ctrl.sv
rtl/bba_datapath.sv
rtl/bitmap_block_allocator_top.sv
rtl/bba_checker.sv
tb/bba_result_checker.sv
tb/tb.sv
